### rtl/core/rhh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Robin Hood hash table package
// Shared sizes, codes, the slot entry layout and the FNV-1a step.
// ----------------------------------------------------------------------------
package rhh_pkg;

	localparam int unsigned SLOTS    = 1024;
	localparam int unsigned IDX_W    = $clog2(SLOTS);
	localparam int unsigned CNT_W    = IDX_W + 1;
	localparam int unsigned KEY_W    = 64;
	localparam int unsigned VAL_W    = 32;
	localparam int unsigned OP_W     = 2;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned IN_W     = OP_W + KEY_W + VAL_W;
	localparam int unsigned IN_PAD_W = ((IN_W + 7) / 8) * 8;
	localparam int unsigned OUT_PAD_W = ((STATUS_W + 7) / 8) * 8;

	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;

	localparam logic [CNT_W-1:0] RESET_MAX = CNT_W'(896);

	localparam logic [OP_W-1:0] OP_SET = 2'd0;
	localparam logic [OP_W-1:0] OP_GET = 2'd1;
	localparam logic [OP_W-1:0] OP_DEL = 2'd2;

	localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] distance;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

	function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] x;
		x = h ^ {24'd0, b};
		return x * FNV_PRIME;
	endfunction

endpackage
`default_nettype wire

### rtl/core/rhh_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rhh_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### rtl/core/robin_hood_hash_table.sv
// Hashing takes one key byte per step; the lookup walk reads, then checks, one
// slot per probe; an insert walk or a delete shift does the same per slot; then
// the status is registered into the result word. One item at a time; slots are
// visited one at a time through the single read port of the slot memory.
// After reset a clearing pass over all 1024 slots empties the slot memory; no
// request is taken then, configuration writes are.
`default_nettype none
// ----------------------------------------------------------------------------
// Robin Hood hash table
// FNV-1a hashed key-value table with linear probing and backward-shift delete.
// ----------------------------------------------------------------------------
module robin_hood_hash_table (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// operation[1:0], key_word[65:2], new_value[97:66], zero fill above
	input  wire logic [rhh_pkg::IN_PAD_W-1:0]   s_tdata,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// status[2:0], zero fill above
	output logic      [rhh_pkg::OUT_PAD_W-1:0]  m_tdata,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [rhh_pkg::CNT_W-1:0]      cfg_data
);
	import rhh_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_HASH, S_F_RD, S_F_CHK, S_I_RD, S_I_CHK,
		S_D_RD, S_D_CHK, S_D_FIN, S_RESP
	} state_t;

	state_t               state_q;
	logic [IDX_W-1:0]     idx_q;
	logic [CNT_W-1:0]     dist_q;
	logic [CNT_W-1:0]     steps_q;
	logic [31:0]          hash_q;
	logic [2:0]           hcnt_q;
	logic [OP_W-1:0]      op_q;
	logic [KEY_W-1:0]     key_q;
	logic [VAL_W-1:0]     val_q;
	logic [KEY_W-1:0]     ckey_q;
	logic [VAL_W-1:0]     cval_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     max_q;
	logic [STATUS_W-1:0]  status_q;

	logic                 we;
	logic [IDX_W-1:0]     waddr, raddr, idx_nx;
	entry_t               wdata, rd;
	logic [ENTRY_W-1:0]   rdata;
	logic [31:0]          h_next;
	logic                 out_free, is_full;

	rhh_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_slots (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd        = entry_t'(rdata);
	assign idx_nx    = (idx_q == IDX_W'(SLOTS - 1)) ? '0 : idx_q + 1'b1;
	assign h_next    = fnv_step(hash_q, key_q[{hcnt_q, 3'b000} +: 8]);
	assign out_free  = !m_tvalid || m_tready;
	assign is_full   = (count_q >= max_q) || (count_q >= CNT_W'(SLOTS));
	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = '0;
		raddr = idx_q;
		unique case (state_q)
			S_CLEAR: begin
				we = 1'b1;
			end
			S_F_CHK: begin
				we    = (op_q == OP_SET) && rd.valid && (dist_q[IDX_W-1:0] <= rd.distance)
					&& (dist_q <= CNT_W'(rd.distance)) && (rd.key == key_q);
				wdata = '{valid: 1'b1, distance: rd.distance, key: rd.key, value: val_q};
			end
			S_I_CHK: begin
				we    = !rd.valid || (dist_q > CNT_W'(rd.distance));
				wdata = '{valid: 1'b1, distance: dist_q[IDX_W-1:0], key: ckey_q,
					value: cval_q};
			end
			S_D_RD: begin
				raddr = idx_nx;
			end
			S_D_CHK: begin
				we    = rd.valid && (rd.distance != '0);
				wdata = '{valid: 1'b1, distance: rd.distance - 1'b1, key: rd.key,
					value: rd.value};
			end
			S_D_FIN: begin
				we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			idx_q    <= '0;
			count_q  <= '0;
			max_q    <= RESET_MAX;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_q <= cfg_data;
			end
			if (m_tvalid && m_tready && (state_q != S_RESP)) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					idx_q <= idx_nx;
					if (idx_q == IDX_W'(SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						op_q    <= s_tdata[OP_W-1:0];
						key_q   <= s_tdata[OP_W +: KEY_W];
						val_q   <= s_tdata[OP_W+KEY_W +: VAL_W];
						hash_q  <= FNV_BASIS;
						hcnt_q  <= '0;
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					hcnt_q <= hcnt_q + 1'b1;
					if (hcnt_q == 3'd7) begin
						// An all-ones hash is folded onto its neighbor.
						hash_q  <= (h_next == '1) ? 32'hFFFF_FFFE : h_next;
						idx_q   <= IDX_W'(((h_next == '1) ? 32'hFFFF_FFFE : h_next) % SLOTS);
						dist_q  <= '0;
						state_q <= S_F_RD;
					end else begin
						hash_q <= h_next;
					end
				end
				S_F_RD: begin
					state_q <= S_F_CHK;
				end
				S_F_CHK: begin
					if (!rd.valid || (dist_q > CNT_W'(rd.distance))
						|| (rd.key != key_q && dist_q == CNT_W'(SLOTS - 1))) begin
						// Key is absent.
						if (op_q == OP_SET && !is_full) begin
							idx_q   <= IDX_W'(hash_q % SLOTS);
							dist_q  <= '0;
							steps_q <= '0;
							ckey_q  <= key_q;
							cval_q  <= val_q;
							state_q <= S_I_RD;
						end else begin
							status_q <= (op_q == OP_SET) ? ST_FULL : ST_NOT_FOUND;
							state_q  <= S_RESP;
						end
					end else if (rd.key == key_q) begin
						case (op_q)
							OP_SET: begin
								status_q <= ST_UPDATED;
								state_q  <= S_RESP;
							end
							OP_GET: begin
								status_q <= ST_FOUND;
								state_q  <= S_RESP;
							end
							OP_DEL: begin
								steps_q <= '0;
								state_q <= S_D_RD;
							end
							default: begin
								status_q <= ST_NOT_FOUND;
								state_q  <= S_RESP;
							end
						endcase
					end else begin
						idx_q   <= idx_nx;
						dist_q  <= dist_q + 1'b1;
						state_q <= S_F_RD;
					end
				end
				S_I_RD: begin
					state_q <= S_I_CHK;
				end
				S_I_CHK: begin
					if (!rd.valid) begin
						count_q  <= count_q + 1'b1;
						status_q <= ST_INSERTED;
						state_q  <= S_RESP;
					end else begin
						if (dist_q > CNT_W'(rd.distance)) begin
							// Richer resident is displaced and carried on.
							ckey_q <= rd.key;
							cval_q <= rd.value;
							dist_q <= CNT_W'(rd.distance) + 1'b1;
						end else begin
							dist_q <= dist_q + 1'b1;
						end
						idx_q   <= idx_nx;
						steps_q <= steps_q + 1'b1;
						if (steps_q == CNT_W'(SLOTS - 1)) begin
							status_q <= ST_FULL;
							state_q  <= S_RESP;
						end else begin
							state_q <= S_I_RD;
						end
					end
				end
				S_D_RD: begin
					state_q <= S_D_CHK;
				end
				S_D_CHK: begin
					if (!rd.valid || rd.distance == '0) begin
						state_q <= S_D_FIN;
					end else begin
						idx_q   <= idx_nx;
						steps_q <= steps_q + 1'b1;
						state_q <= (steps_q == CNT_W'(SLOTS - 1)) ? S_D_FIN : S_D_RD;
					end
				end
				S_D_FIN: begin
					count_q  <= count_q - 1'b1;
					status_q <= ST_DELETED;
					state_q  <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tdata  <= OUT_PAD_W'(status_q);
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

### rtl/core/rhh_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Robin Hood hash table port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module rhh_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tvalid,
	input wire logic                          s_tready,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [rhh_pkg::OUT_PAD_W-1:0] m_tdata
);
	import rhh_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[STATUS_W-1:0] <= ST_FULL) && (m_tdata[OUT_PAD_W-1:STATUS_W] == '0))
		else $error("status code out of range");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in work");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared without a request in work");
endmodule

bind robin_hood_hash_table rhh_checker u_rhh_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

### dv/robin_hood_hash_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Robin Hood hash table testbench
// Drives set, get, delete and unused-code requests through the stream port, keeps its own
// model of the slot table to predict each status word, and changes the load
// limit between phases while the table is idle.
// ----------------------------------------------------------------------------
module robin_hood_hash_table_tb;
	import rhh_pkg::*;

	localparam logic [OP_W-1:0] OP_NONE = 2'd3;
	localparam int unsigned STALL_LIMIT = 20000;

	typedef struct {
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] val;
	} request_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_PAD_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_PAD_W-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CNT_W-1:0] cfg_data = '0;

	// Shadow copy of the slot table.
	bit          tbl_valid [SLOTS];
	logic [31:0] tbl_hash  [SLOTS];
	int unsigned tbl_dist  [SLOTS];
	logic [63:0] tbl_key   [SLOTS];
	logic [31:0] tbl_value [SLOTS];
	int unsigned tbl_count;
	int unsigned load_limit;

	request_t pending_reqs[$];
	request_t offered;
	logic [STATUS_W-1:0] status_q[$];
	logic [63:0] key_pool[512];
	int unsigned errors;
	int unsigned src_idle;
	int unsigned snk_idle;
	int unsigned hold_left;
	int unsigned quiet_cycles;
	bit taken;

	robin_hood_hash_table u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] key_hash(input logic [63:0] key);
		logic [31:0] h;
		h = 32'd2166136261;
		for (int i = 0; i < 8; i++) begin
			h = (h ^ {24'd0, key[8*i +: 8]}) * 32'd16777619;
		end
		return (h == 32'hFFFF_FFFF) ? 32'hFFFF_FFFE : h;
	endfunction

	// Applies one request to the shadow table and returns its status.
	function automatic logic [STATUS_W-1:0] table_update(input request_t r);
		logic [31:0] h, c_hash, t_hash;
		logic [63:0] c_key, t_key;
		logic [31:0] c_val, t_val;
		int unsigned idx, nx, c_dist, t_dist;
		int pos;
		h = key_hash(r.key);
		idx = h % SLOTS;
		pos = -1;
		for (int unsigned d = 0; d < SLOTS; d++) begin
			if (!tbl_valid[idx] || d > tbl_dist[idx]) break;
			if (tbl_hash[idx] == h && tbl_key[idx] == r.key) begin
				pos = idx;
				break;
			end
			idx = (idx + 1) % SLOTS;
		end
		if (r.op == OP_GET) begin
			return (pos >= 0) ? ST_FOUND : ST_NOT_FOUND;
		end else if (r.op == OP_DEL) begin
			if (pos < 0) return ST_NOT_FOUND;
			idx = pos;
			// Backward shift until a gap or an entry sitting in its home slot.
			for (int unsigned n = 0; n < SLOTS; n++) begin
				nx = (idx + 1) % SLOTS;
				if (!tbl_valid[nx] || tbl_dist[nx] == 0) break;
				tbl_hash[idx]  = tbl_hash[nx];
				tbl_key[idx]   = tbl_key[nx];
				tbl_value[idx] = tbl_value[nx];
				tbl_dist[idx]  = tbl_dist[nx] - 1;
				tbl_valid[idx] = 1'b1;
				idx = nx;
			end
			tbl_valid[idx] = 1'b0;
			tbl_count--;
			return ST_DELETED;
		end else if (r.op == OP_SET) begin
			if (pos >= 0) begin
				tbl_value[pos] = r.val;
				return ST_UPDATED;
			end
			if (tbl_count >= load_limit || tbl_count >= SLOTS) return ST_FULL;
			idx = h % SLOTS;
			c_hash = h;
			c_key = r.key;
			c_val = r.val;
			c_dist = 0;
			for (int unsigned n = 0; n < SLOTS; n++) begin
				if (!tbl_valid[idx]) begin
					tbl_valid[idx] = 1'b1;
					tbl_hash[idx]  = c_hash;
					tbl_dist[idx]  = c_dist;
					tbl_key[idx]   = c_key;
					tbl_value[idx] = c_val;
					tbl_count++;
					return ST_INSERTED;
				end
				if (c_dist > tbl_dist[idx]) begin
					t_hash = tbl_hash[idx];
					t_dist = tbl_dist[idx];
					t_key = tbl_key[idx];
					t_val = tbl_value[idx];
					tbl_hash[idx]  = c_hash;
					tbl_dist[idx]  = c_dist;
					tbl_key[idx]   = c_key;
					tbl_value[idx] = c_val;
					c_hash = t_hash;
					c_dist = t_dist;
					c_key = t_key;
					c_val = t_val;
				end
				idx = (idx + 1) % SLOTS;
				c_dist++;
			end
			return ST_FULL;
		end
		return ST_NOT_FOUND;
	endfunction

	// Acceptance of a request word: predict its status right away, since the
	// block serves one request at a time.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			status_q.push_back(table_update(offered));
			taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (!s_tvalid || taken) begin
			taken = 1'b0;
			if (pending_reqs.size() > 0 && $urandom_range(99) >= src_idle) begin
				offered = pending_reqs.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {{(IN_PAD_W - IN_W){1'b0}}, offered.val, offered.key, offered.op};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (status_q.size() == 0) begin
				$display("%0t: unexpected status word, expected none, actual %0d",
					$realtime, m_tdata);
				errors++;
			end else if (m_tdata !== {{(OUT_PAD_W - STATUS_W){1'b0}}, status_q[0]}) begin
				$display("%0t: status mismatch, expected %0d, actual %0d",
					$realtime, status_q[0], m_tdata);
				errors++;
				void'(status_q.pop_front());
			end else begin
				void'(status_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else if (++quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic set_limit(input int unsigned v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v[CNT_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		load_limit = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || status_q.size() > 0 || s_tvalid) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic push_req(input logic [1:0] op, input logic [63:0] key,
			input logic [31:0] val);
		request_t r;
		r.op = op;
		r.key = key;
		r.val = val;
		pending_reqs.push_back(r);
	endtask

	task automatic random_reqs(input int unsigned count, input int unsigned pool_n);
		int unsigned pick;
		logic [1:0] op;
		logic [63:0] key;
		for (int i = 0; i < 512; i++) key_pool[i] = {$urandom, $urandom};
		for (int unsigned i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			op = (pick < 45) ? OP_SET : (pick < 70) ? OP_GET : (pick < 95) ? OP_DEL : OP_NONE;
			key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(pool_n - 1)]
				: {$urandom, $urandom};
			push_req(op, key, $urandom);
		end
	endtask

	initial begin
		for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
		tbl_count = 0;
		load_limit = 896;
		errors = 0;
		quiet_cycles = 0;
		hold_left = 0;
		taken = 1'b0;
		src_idle = 24;
		snk_idle = 84;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: every operation, unused code, extreme keys and values.
		push_req(OP_SET, 64'h0123_4567_89AB_CDEF, 32'h0000_0000);
		push_req(OP_SET, 64'h0123_4567_89AB_CDEF, 32'hFFFF_FFFF);
		push_req(OP_GET, 64'h0123_4567_89AB_CDEF, 32'h0);
		push_req(OP_GET, 64'h0, 32'h0);
		push_req(OP_SET, 64'h0, 32'h5A5A_5A5A);
		push_req(OP_SET, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		push_req(OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
		push_req(OP_NONE, 64'h0, 32'hFFFF_FFFF);
		push_req(OP_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
		push_req(OP_DEL, 64'h0123_4567_89AB_CDEF, 32'h0);
		push_req(OP_DEL, 64'h0123_4567_89AB_CDEF, 32'h0);
		push_req(OP_GET, 64'h0123_4567_89AB_CDEF, 32'h0);
		drain();

		// A limit at or below the count refuses only new keys; present ones update.
		set_limit(0);
		push_req(OP_SET, 64'h0, 32'h1234_5678);
		push_req(OP_SET, 64'hDEAD_BEEF_0000_0001, 32'h1);
		push_req(OP_GET, 64'h0, 32'h0);
		drain();
		set_limit(3);
		push_req(OP_SET, 64'hDEAD_BEEF_0000_0001, 32'h1);
		push_req(OP_SET, 64'hDEAD_BEEF_0000_0002, 32'h2);
		push_req(OP_DEL, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
		push_req(OP_SET, 64'hDEAD_BEEF_0000_0002, 32'h3);
		drain();

		// Large limit with a wide key pool builds long probe chains.
		set_limit(1024);
		random_reqs(250, 400);
		drain();

		set_limit(20);
		src_idle = 84;
		snk_idle = 24;
		@(posedge clk);
		hold_left = 300;
		random_reqs(200, 40);
		drain();

		set_limit(896);
		src_idle = 0;
		snk_idle = 0;
		random_reqs(250, 300);
		drain();

		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

### files.f
rtl/core/rhh_pkg.sv
rtl/core/rhh_ram.sv
rtl/core/robin_hood_hash_table.sv
rtl/core/rhh_checker.sv
dv/robin_hood_hash_table_tb.sv
